[rtl/ubx_ffc_pkg.sv]
// ---------------------------------------------------------------------------
// ubx_ffc_pkg
// Shared constants for the UBX frame filter and checker.
// ---------------------------------------------------------------------------
package ubx_ffc_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [7:0]  RESET_MESSAGE_CLASS  = 8'h01;
  localparam logic [7:0]  RESET_MESSAGE_ID     = 8'h07;
  localparam logic [15:0] RESET_PAYLOAD_LENGTH = 16'd92;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MESSAGE_CLASS  = 2'd0,
    CFG_MESSAGE_ID     = 2'd1,
    CFG_PAYLOAD_LENGTH = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_NONE = 2'd0,
    STATUS_GOOD = 2'd1,
    STATUS_BAD  = 2'd2,
    STATUS_RSVD = 2'd3
  } frame_status_t;

endpackage

[rtl/ubx_ffc_ifs.sv]
// ---------------------------------------------------------------------------
// ubx_ffc_ifs
// Valid/ready channels for receiver bytes and per-byte results.
// ---------------------------------------------------------------------------
interface ubx_ffc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubx_ffc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [15:0] payload_index;
  logic [1:0]  frame_status;

  modport source (output valid, output payload_byte, output payload_valid,
                  output payload_index, output frame_status, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input payload_index, input frame_status, output ready);
endinterface

[rtl/ubx_frame_filter_checker_top.sv]
// ---------------------------------------------------------------------------
// ubx_frame_filter_checker_top
// Streams UBX frames byte by byte: sync hunt, header filter, payload echo
// with index and Fletcher-8 check at the end of each frame.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        rx_byte[7:0]
//  out_ch    out  valid/ready        payload_byte, payload_valid,
//                                    payload_index[15:0], frame_status[1:0]
//  cfg       in   cfg_we, no stall   cfg_index[1:0], cfg_data[15:0]
//
//  one item per cycle sustained while out_ch is ready; each item passes the input reg, then the result reg
//  the frame state machine updates as an item moves from input to result reg
//  rst is synchronous: config returns to class 0x01, id 0x07, length 92
//  a stalled result holds the result reg; one more item waits in the input reg
// ---------------------------------------------------------------------------
module ubx_frame_filter_checker_top (
  input  logic                                 clk,
  input  logic                                 rst,
  ubx_ffc_in_if.sink                           in_ch,
  ubx_ffc_out_if.source                        out_ch,
  input  logic                                 cfg_we,
  input  logic [ubx_ffc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ubx_ffc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ubx_ffc_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  // configuration
  logic [7:0]  message_class;
  logic [7:0]  message_id;
  logic [15:0] payload_length;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // frame state
  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  length_low, length_low_next;
  logic [7:0]  first_check, first_check_next;

  // result register
  logic          out_valid_q;
  logic [7:0]    payload_byte_q, payload_byte_next;
  logic          payload_valid_q, payload_valid_next;
  logic [15:0]   payload_index_q, payload_index_next;
  frame_status_t frame_status_q, frame_status_next;

  logic       advance;
  logic [7:0] acc_a, acc_b;
  logic [7:0] b;
  phase_t     resync_phase;

  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  assign b            = in_byte_q;
  assign acc_a        = sum_a + b;
  assign acc_b        = sum_b + acc_a;
  assign resync_phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    length_low_next    = length_low;
    first_check_next   = first_check;
    payload_byte_next  = 8'd0;
    payload_valid_next = 1'b0;
    payload_index_next = 16'd0;
    frame_status_next  = STATUS_NONE;
    case (phase)
      PH_SYNC2: begin
        phase_next = (b == SYNC_SECOND) ? PH_CLASS : resync_phase;
      end
      PH_CLASS: begin
        if (b == message_class) begin
          // checksum restarts at the class byte
          sum_a_next = b;
          sum_b_next = b;
          phase_next = PH_ID;
        end else begin
          phase_next = resync_phase;
        end
      end
      PH_ID: begin
        if (b == message_id) begin
          sum_a_next = acc_a;
          sum_b_next = acc_b;
          phase_next = PH_LEN_LO;
        end else begin
          phase_next = resync_phase;
        end
      end
      PH_LEN_LO: begin
        length_low_next = b;
        sum_a_next      = acc_a;
        sum_b_next      = acc_b;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if ({b, length_low} == payload_length) begin
          sum_a_next      = acc_a;
          sum_b_next      = acc_b;
          byte_count_next = 16'd0;
          phase_next      = ({b, length_low} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
        end else begin
          phase_next = resync_phase;
        end
      end
      PH_PAYLOAD: begin
        payload_byte_next  = b;
        payload_valid_next = 1'b1;
        payload_index_next = byte_count;
        sum_a_next         = acc_a;
        sum_b_next         = acc_b;
        byte_count_next    = byte_count + 16'd1;
        // live length compare, wraps at 2^16
        if (byte_count_next == payload_length) begin
          phase_next = PH_CK_A;
        end
      end
      PH_CK_A: begin
        first_check_next = b;
        phase_next       = PH_CK_B;
      end
      PH_CK_B: begin
        frame_status_next = (first_check == sum_a && b == sum_b) ? STATUS_GOOD
                                                                 : STATUS_BAD;
        phase_next        = PH_HUNT;
      end
      default: begin
        phase_next = resync_phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_class  <= RESET_MESSAGE_CLASS;
      message_id     <= RESET_MESSAGE_ID;
      payload_length <= RESET_PAYLOAD_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MESSAGE_CLASS:  message_class  <= cfg_data[7:0];
        CFG_MESSAGE_ID:     message_id     <= cfg_data[7:0];
        CFG_PAYLOAD_LENGTH: payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_byte_q <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= 16'd0;
      sum_a       <= 8'd0;
      sum_b       <= 8'd0;
      length_low  <= 8'd0;
      first_check <= 8'd0;
    end else if (advance) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      sum_a       <= sum_a_next;
      sum_b       <= sum_b_next;
      length_low  <= length_low_next;
      first_check <= first_check_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
    if (advance) begin
      payload_byte_q  <= payload_byte_next;
      payload_valid_q <= payload_valid_next;
      payload_index_q <= payload_index_next;
      frame_status_q  <= frame_status_next;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.payload_byte  = payload_byte_q;
  assign out_ch.payload_valid = payload_valid_q;
  assign out_ch.payload_index = payload_index_q;
  assign out_ch.frame_status  = frame_status_q;

  // a payload item never also ends a frame
  assert property (@(posedge clk) disable iff (rst)
    out_valid_q && payload_valid_q |-> frame_status_q == STATUS_NONE)
    else $error("payload item carries a frame status");

  // a frame status only comes out of the second checksum byte
  assert property (@(posedge clk) disable iff (rst)
    advance && phase != PH_CK_B |=> frame_status_q == STATUS_NONE)
    else $error("frame status outside checksum byte");

  // payload index follows the running byte count
  assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_PAYLOAD |=> payload_index_q == $past(byte_count))
    else $error("payload index does not match byte count");

  // a waiting input item is neither dropped nor overwritten
  assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("input item lost while result stalled");

endmodule

[verif/ubx_ffc_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ubx_ffc_checker
// Watches the byte and result channels and the register port of the UBX
// frame filter. Runs its own frame parser on every accepted byte, queues the
// predicted result and compares each accepted result field by field.
// ---------------------------------------------------------------------------
module ubx_ffc_checker (
  input  logic                                clk,
  input  logic                                rst,
  ubx_ffc_in_if                               in_mon,
  ubx_ffc_out_if                              out_mon,
  input  logic                                cfg_we,
  input  logic [ubx_ffc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ubx_ffc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                  failures,
  output int                                  outstanding
);
  import ubx_ffc_pkg::*;

  localparam int MAX_SHOWN = 200;

  typedef enum logic [3:0] {
    ST_HUNT, ST_SYNC2, ST_CLASS, ST_ID, ST_LEN_LO, ST_LEN_HI,
    ST_PAYLOAD, ST_CK_A, ST_CK_B
  } parse_state_t;

  typedef struct {
    logic [7:0]    data;
    logic          is_payload;
    logic [15:0]   index;
    frame_status_t status;
  } byte_result_t;

  logic [7:0]   want_class;
  logic [7:0]   want_id;
  logic [15:0]  want_length;

  parse_state_t state;
  logic [15:0]  pay_count;
  logic [7:0]   fl_a;
  logic [7:0]   fl_b;
  logic [7:0]   len_lo;
  logic [7:0]   rx_ck_a;

  byte_result_t awaited_results[$];
  int           results_seen;
  int           shown;

  initial begin
    failures = 0;
    shown = 0;
    results_seen = 0;
  end

  task automatic report(input string msg);
    failures++;
    if (shown < MAX_SHOWN) begin
      $display("[%0t] %s", $time, msg);
      shown++;
    end
  endtask

  // a bad header byte that is itself a first sync byte starts a new frame
  function automatic parse_state_t restart_from(input logic [7:0] b);
    return (b == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
  endfunction

  function automatic void fletcher_add(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endfunction

  function automatic byte_result_t parse_byte(input logic [7:0] b);
    byte_result_t r;
    logic [15:0]  declared;
    r.data = '0;
    r.is_payload = 1'b0;
    r.index = '0;
    r.status = STATUS_NONE;
    case (state)
      ST_SYNC2: begin
        state = (b == SYNC_SECOND) ? ST_CLASS : restart_from(b);
      end
      ST_CLASS: begin
        if (b == want_class) begin
          fl_a = '0;
          fl_b = '0;
          fletcher_add(b);
          state = ST_ID;
        end else begin
          state = restart_from(b);
        end
      end
      ST_ID: begin
        if (b == want_id) begin
          fletcher_add(b);
          state = ST_LEN_LO;
        end else begin
          state = restart_from(b);
        end
      end
      ST_LEN_LO: begin
        len_lo = b;
        fletcher_add(b);
        state = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        declared = {b, len_lo};
        if (declared == want_length) begin
          fletcher_add(b);
          pay_count = '0;
          state = (declared == 16'd0) ? ST_CK_A : ST_PAYLOAD;
        end else begin
          state = restart_from(b);
        end
      end
      ST_PAYLOAD: begin
        r.data = b;
        r.is_payload = 1'b1;
        r.index = pay_count;
        fletcher_add(b);
        // end of payload follows the live length register
        pay_count = pay_count + 16'd1;
        if (pay_count == want_length) state = ST_CK_A;
      end
      ST_CK_A: begin
        rx_ck_a = b;
        state = ST_CK_B;
      end
      ST_CK_B: begin
        r.status = (rx_ck_a == fl_a && b == fl_b) ? STATUS_GOOD : STATUS_BAD;
        state = ST_HUNT;
      end
      default: begin
        state = restart_from(b);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    byte_result_t want;
    if (rst) begin
      want_class = RESET_MESSAGE_CLASS;
      want_id = RESET_MESSAGE_ID;
      want_length = RESET_PAYLOAD_LENGTH;
      state = ST_HUNT;
      pay_count = '0;
      fl_a = '0;
      fl_b = '0;
      len_lo = '0;
      rx_ck_a = '0;
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MESSAGE_CLASS:  want_class = cfg_data[7:0];
          CFG_MESSAGE_ID:     want_id = cfg_data[7:0];
          CFG_PAYLOAD_LENGTH: want_length = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) awaited_results.push_back(parse_byte(in_mon.rx_byte));
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          report($sformatf("result %0d arrived with no item outstanding", results_seen));
        end else begin
          want = awaited_results.pop_front();
          if (out_mon.payload_byte !== want.data)
            report($sformatf("result %0d payload_byte: got %02h, expected %02h",
                             results_seen, out_mon.payload_byte, want.data));
          if (out_mon.payload_valid !== want.is_payload)
            report($sformatf("result %0d payload_valid: got %0b, expected %0b",
                             results_seen, out_mon.payload_valid, want.is_payload));
          if (out_mon.payload_index !== want.index)
            report($sformatf("result %0d payload_index: got %0d, expected %0d",
                             results_seen, out_mon.payload_index, want.index));
          if (out_mon.frame_status !== want.status)
            report($sformatf("result %0d frame_status: got %0d, expected %0d",
                             results_seen, out_mon.frame_status, want.status));
        end
        results_seen++;
      end
      outstanding <= awaited_results.size();
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Byte stream stimulus for the UBX frame filter: directed frames for sync
// repeats, header rejects, empty payloads and a length change mid-frame,
// then random streams of good, corrupted, truncated and rejected frames
// under several register settings and handshake idling patterns.
// ---------------------------------------------------------------------------
module tb;
  import ubx_ffc_pkg::*;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {CK_INTACT, CK_FLIP_A, CK_FLIP_B} ck_flaw_t;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ubx_ffc_in_if  in_ch ();
  ubx_ffc_out_if out_ch ();

  int         failures;
  int         outstanding;
  int         src_pct;
  int         snk_pct;
  int         sent;
  int         cycles;
  logic       hold_off;
  logic       pressure_go;
  logic [7:0] run_a;
  logic [7:0] run_b;
  logic [7:0] cur_class;
  logic [7:0] cur_id;
  logic [15:0] cur_len;

  ubx_frame_filter_checker_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ubx_ffc_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_pct);
    end
  end

  // long receiver hold-off so the block fills and pushes back on the sender
  initial begin
    hold_off = 1'b0;
    wait (pressure_go === 1'b1);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sent++;
  endtask

  task automatic send_summed(input logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
    send_byte(b);
  endtask

  task automatic send_header(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input int extra_sync);
    repeat (extra_sync) send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    run_a = '0;
    run_b = '0;
    send_summed(cls);
    send_summed(id);
    send_summed(len[7:0]);
    send_summed(len[15:8]);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_summed(8'($urandom_range(255)));
  endtask

  task automatic send_check(input ck_flaw_t flaw);
    logic [7:0] a;
    logic [7:0] b;
    a = run_a;
    b = run_b;
    if (flaw == CK_FLIP_A) a = a ^ 8'($urandom_range(255, 1));
    if (flaw == CK_FLIP_B) b = b ^ 8'($urandom_range(255, 1));
    send_byte(a);
    send_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input int n_pay,
                            input ck_flaw_t flaw, input int extra_sync);
    send_header(cls, id, len, extra_sync);
    send_payload(n_pay);
    send_check(flaw);
  endtask

  // drain every outstanding item before touching the registers
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input bit poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MESSAGE_CLASS;
    cfg_data <= {8'($urandom), cls};
    @(posedge clk);
    cfg_index <= CFG_MESSAGE_ID;
    cfg_data <= {8'($urandom), id};
    @(posedge clk);
    cfg_index <= CFG_PAYLOAD_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_class = cls;
    cur_id = id;
    cur_len = len;
  endtask

  task automatic set_idle(input idle_mode_t m);
    src_pct = (m == IDLE_SENDER) ? 50 : (m == IDLE_BOTH) ? 13 : 0;
    snk_pct <= (m == IDLE_RECEIVER) ? 50 : (m == IDLE_BOTH) ? 13 : 0;
  endtask

  task automatic run_phase(input logic [7:0] cls, input logic [7:0] id,
                           input logic [15:0] len, input idle_mode_t m,
                           input int n_items, input bit squeeze);
    int          start;
    int          pick;
    int          extra;
    logic [7:0]  cls_x;
    logic [7:0]  id_x;
    logic [15:0] len_x;
    logic [7:0]  b;
    logic [7:0]  pad;
    wait_idle();
    program_regs(cls, id, len, 1'b0);
    set_idle(m);
    if (squeeze) pressure_go <= 1'b1;
    start = sent;
    while (sent - start < n_items) begin
      pick = $urandom_range(99);
      extra = ($urandom_range(99) < 20) ? $urandom_range(2, 1) : 0;
      if (pick < 55) begin
        send_frame(cur_class, cur_id, cur_len, int'(cur_len), CK_INTACT, extra);
      end else if (pick < 65) begin
        send_frame(cur_class, cur_id, cur_len, int'(cur_len),
                   ($urandom_range(1) != 0) ? CK_FLIP_A : CK_FLIP_B, extra);
      end else if (pick < 75) begin
        cls_x = cur_class;
        id_x = cur_id;
        len_x = cur_len;
        case ($urandom_range(3))
          0: begin
            send_byte(SYNC_FIRST);
            do b = 8'($urandom_range(255)); while (b == SYNC_SECOND);
            send_byte(($urandom_range(1) != 0) ? SYNC_FIRST : b);
          end
          1: cls_x = cls_x ^ 8'($urandom_range(255, 1));
          2: id_x = id_x ^ 8'($urandom_range(255, 1));
          default: len_x = len_x ^ 16'($urandom_range(65535, 1));
        endcase
        if (cls_x != cur_class || id_x != cur_id || len_x != cur_len)
          send_frame(cls_x, id_x, len_x, int'(cur_len), CK_INTACT, extra);
      end else if (pick < 82) begin
        // cut short: the following items are absorbed into this frame
        send_header(cur_class, cur_id, cur_len, extra);
        send_payload((cur_len == 0) ? 0 : $urandom_range(int'(cur_len) - 1));
      end else begin
        repeat ($urandom_range(8, 1))
          send_byte(($urandom_range(99) < 15) ? SYNC_FIRST : 8'($urandom_range(255)));
      end
    end
    // pad bytes that cannot open a frame walk any frame in progress to its end
    do pad = 8'($urandom); while (pad == cur_class || pad == cur_id || pad == SYNC_FIRST);
    repeat (int'(cur_len) + 8) send_byte(pad);
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MESSAGE_CLASS;
    cfg_data <= '0;
    pressure_go <= 1'b0;
    snk_pct <= 0;
    src_pct = 0;
    sent = 0;
    run_a = '0;
    run_b = '0;
    cur_class = RESET_MESSAGE_CLASS;
    cur_id = RESET_MESSAGE_ID;
    cur_len = RESET_PAYLOAD_LENGTH;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header under reset settings, then the length shrinks mid-frame
    send_header(RESET_MESSAGE_CLASS, RESET_MESSAGE_ID, RESET_PAYLOAD_LENGTH, 0);
    wait_idle();
    program_regs(RESET_MESSAGE_CLASS, RESET_MESSAGE_ID, 16'd2, 1'b1);
    send_payload(2);
    send_check(CK_INTACT);

    // repeated sync byte and an empty payload at the byte extremes
    wait_idle();
    program_regs(8'h00, 8'hFF, 16'd0, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(8'h00, 8'hFF, 16'd0, 1);
    send_check(CK_INTACT);

    // id rejected by a sync byte, which restarts the frame at once
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    run_a = '0;
    run_b = '0;
    send_summed(8'h00);
    send_summed(8'hFF);
    send_summed(8'h00);
    send_summed(8'h00);
    send_check(CK_FLIP_B);

    run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(12, 1)), IDLE_NONE, 150, 1'b0);
    run_phase(8'hFF, 8'h00, 16'd1, IDLE_SENDER, 150, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(24, 2)), IDLE_RECEIVER, 150,
              1'b1);
    run_phase(8'($urandom), 8'($urandom), 16'd0, IDLE_BOTH, 150, 1'b0);

    // largest declared length, then the frame is cut down to a few bytes
    wait_idle();
    program_regs(8'($urandom), 8'($urandom), 16'hFFFF, 1'b0);
    set_idle(IDLE_NONE);
    send_header(cur_class, cur_id, 16'h00FF, 0);
    send_header(cur_class, cur_id, 16'hFFFF, 0);
    send_payload(3);
    wait_idle();
    program_regs(cur_class, cur_id, 16'd5, 1'b0);
    send_payload(2);
    send_check(CK_INTACT);

    run_phase(8'h01, 8'h07, 16'd92, IDLE_BOTH, 200, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
